>>> rtl/core/cluster_head_election_top_assert.svh
// Assertion macros for the cluster head election checker.
`ifndef CLUSTER_HEAD_ELECTION_TOP_ASSERT_SVH
`define CLUSTER_HEAD_ELECTION_TOP_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define CHE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cluster head election check failed");

// Check that a condition implies another in the next cycle.
`define CHE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cluster head election check failed");

`endif

>>> rtl/core/che_pkg.sv
// Shared types and constants of the cluster head election block.
package che_pkg;

  localparam int NODES     = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int COORD_W   = 16;
  localparam int RAND_W    = 16;
  localparam int ROUND_W   = 16;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int DIST_W    = SQ_W + 1;
  localparam int DIV_W     = ROUND_W + 1;
  localparam int EPOCH_MAX = 64;

  localparam logic [CNT_W-1:0] EPOCH_RST = CNT_W'(20);
  localparam logic [CNT_W-1:0] NODES_RST = CNT_W'(64);

  localparam logic [2:0] ACT_LOAD   = 3'd0;
  localparam logic [2:0] ACT_ALIVE  = 3'd1;
  localparam logic [2:0] ACT_ROUND  = 3'd2;
  localparam logic [2:0] ACT_DRAW   = 3'd3;
  localparam logic [2:0] ACT_FINISH = 3'd4;

  localparam logic CFG_EPOCH = 1'b0;
  localparam logic CFG_NODES = 1'b1;

  localparam logic SCAN_COUNT = 1'b0;
  localparam logic SCAN_PICK  = 1'b1;

  typedef struct packed {
    logic [2:0]         action;
    logic [IDX_W-1:0]   node_index;
    logic [COORD_W-1:0] x_position;
    logic [COORD_W-1:0] y_position;
    logic               node_alive;
    logic [ROUND_W-1:0] round_number;
    logic [RAND_W-1:0]  random_value;
  } che_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_node;
    logic [IDX_W-1:0] head_index;
    logic             has_head;
    logic             is_head;
    logic [CNT_W-1:0] head_count;
    logic             last;
  } che_out_t;

  // Broadcast command from the sequencer to every cell.
  typedef struct packed {
    logic               load;
    logic               set_alive;
    logic               clr_head;
    logic               clr_served;
    logic               draw;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               alive;
    logic [CNT_W-1:0]   nodes;
  } che_cmd_t;

  // Token that walks the row to count flags or to place the fallback head.
  typedef struct packed {
    logic             valid;
    logic             mode;
    logic [CNT_W-1:0] heads;
    logic [CNT_W-1:0] elig;
    logic [CNT_W-1:0] pick;
    logic             done;
  } che_scan_t;

  // Query for one node: picks up its own data, then its nearest head.
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   node;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               alive;
    logic               head;
    logic [DIST_W-1:0]  best;
    logic [IDX_W-1:0]   hidx;
    logic               has;
  } che_qry_t;

endpackage

>>> rtl/core/che_div.sv
// Bit-serial remainder unit, one dividend bit per cycle.
module che_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [che_pkg::DIV_W-1:0]   num_i,
  input  logic [che_pkg::CNT_W-1:0]   den_i,
  output logic                        done_o,
  output logic [che_pkg::CNT_W-1:0]   rem_o
);
  import che_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);

  logic [DIV_W-1:0]  num_q;
  logic [CNT_W-1:0]  den_q;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0] cnt_q;
  logic              run_q, done_q;
  logic [CNT_W:0]    trial;

  always_comb begin
    trial = {rem_q, num_q[DIV_W-1]};
    if (trial >= {1'b0, den_q}) begin
      rem_d = CNT_W'(trial - {1'b0, den_q});
    end else begin
      rem_d = trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= STEP_W'(DIV_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[DIV_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/core/che_cell.sv
// One node cell: node state plus scan, capture and distance stages.
module che_cell #(
  parameter logic [che_pkg::IDX_W-1:0] IDX = '0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  che_pkg::che_cmd_t  cmd_i,
  input  che_pkg::che_scan_t scan_i,
  output che_pkg::che_scan_t scan_o,
  input  che_pkg::che_qry_t  qa_i,
  output che_pkg::che_qry_t  qa_o,
  input  che_pkg::che_qry_t  qb_i,
  output che_pkg::che_qry_t  qb_o
);
  import che_pkg::*;

  logic [COORD_W-1:0] x_q, y_q;
  logic               alive_q, served_q, head_q;
  logic               inuse, sel, elig_here, head_here, pick_hit;
  che_scan_t          scan_q, scan_d;
  che_qry_t           qa_q, qa_d, qs_q, qb_q, qb_d;
  logic [COORD_W-1:0] dx, dy;
  logic [SQ_W-1:0]    dx2_q, dy2_q;
  logic               cand_q;
  logic [DIST_W-1:0]  sq_sum;

  assign inuse     = {1'b0, IDX} < cmd_i.nodes;
  assign sel       = cmd_i.idx == IDX;
  assign elig_here = inuse && alive_q && !served_q;
  assign head_here = inuse && alive_q && head_q;
  assign pick_hit  = scan_i.valid && scan_i.mode == SCAN_PICK && elig_here &&
                     !scan_i.done && scan_i.pick == '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && sel) begin
      x_q <= cmd_i.x;
      y_q <= cmd_i.y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q  <= 1'b0;
      served_q <= 1'b0;
      head_q   <= 1'b0;
    end else begin
      if ((cmd_i.load || cmd_i.set_alive) && sel) begin
        alive_q <= cmd_i.alive;
      end
      if (cmd_i.clr_head) begin
        head_q <= 1'b0;
      end
      if (cmd_i.clr_served) begin
        served_q <= 1'b0;
      end
      if ((cmd_i.draw && sel && alive_q && !served_q) || pick_hit) begin
        head_q   <= 1'b1;
        served_q <= 1'b1;
      end
    end
  end

  // Scan token: count flags, or count down to the fallback pick.
  always_comb begin
    scan_d = scan_i;
    if (scan_i.valid) begin
      if (scan_i.mode == SCAN_COUNT) begin
        scan_d.heads = scan_i.heads + CNT_W'(head_here);
        scan_d.elig  = scan_i.elig + CNT_W'(elig_here);
      end else if (elig_here && !scan_i.done) begin
        if (scan_i.pick == '0) begin
          scan_d.done = 1'b1;
        end else begin
          scan_d.pick = scan_i.pick - CNT_W'(1);
        end
      end
    end
  end

  // Capture pass: the query collects its own node's data.
  always_comb begin
    qa_d = qa_i;
    if (qa_i.node == IDX) begin
      qa_d.x     = x_q;
      qa_d.y     = y_q;
      qa_d.alive = alive_q;
      qa_d.head  = head_q;
    end
  end

  assign dx = (qb_i.x >= x_q) ? qb_i.x - x_q : x_q - qb_i.x;
  assign dy = (qb_i.y >= y_q) ? qb_i.y - y_q : y_q - qb_i.y;
  assign sq_sum = {1'b0, dx2_q} + {1'b0, dy2_q};

  // Distance pass: keep the nearest head, strict compare keeps the lower index.
  always_comb begin
    qb_d = qs_q;
    if (qs_q.valid && cand_q && (!qs_q.has || sq_sum < qs_q.best)) begin
      qb_d.best = sq_sum;
      qb_d.hidx = IDX;
      qb_d.has  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    dx2_q  <= {{COORD_W{1'b0}}, dx} * {{COORD_W{1'b0}}, dx};
    dy2_q  <= {{COORD_W{1'b0}}, dy} * {{COORD_W{1'b0}}, dy};
    cand_q <= head_here;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      qa_q   <= '0;
      qs_q   <= '0;
      qb_q   <= '0;
    end else begin
      scan_q <= scan_d;
      qa_q   <= qa_d;
      qs_q   <= qb_i;
      qb_q   <= qb_d;
    end
  end

  assign scan_o = scan_q;
  assign qa_o   = qa_q;
  assign qb_o   = qb_q;

endmodule

>>> rtl/core/cluster_head_election_top.sv
// Top level of the cluster head election block: sequencer and the row of node cells.
//
// Usage:
//   Drive an input word on in_i with start_i high; it is taken at a rising edge
//   where busy_o is low. Load, set alive and draw take effect at that edge and
//   leave busy_o low. Begin round runs the serial remainder unit to get the epoch
//   phase, then clears the head flags and, at epoch start, the served flags.
//   Finish walks a count token through the 64 cells. With no live head and at
//   least one eligible node, it finds the fallback pick by a remainder and a
//   second token walk. Then one query per node in use enters the row each cycle;
//   a query passes 64 capture stages and 64 two-stage distance cells, and the
//   results leave the row back to back.
//   Each result word sits on res_o for one cycle with res_valid_o high; the
//   receiver cannot hold it off. last marks the final word of the finish.
//   The user writes configuration (cfg_we_i/cfg_idx_i/cfg_data_i) only while idle;
//   the block does not enforce this. Reset clears all flags, the phase, and
//   sets epoch length 20 and 64 nodes; positions stay unknown until loaded.
module cluster_head_election_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  che_pkg::che_in_t          in_i,
  output logic                      res_valid_o,
  output che_pkg::che_out_t         res_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [che_pkg::CNT_W-1:0] cfg_data_i
);
  import che_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_ASSIGN = 3'd3;

  localparam int PROD_W = RAND_W + CNT_W;
  localparam logic [PROD_W-1:0] DRAW_LIM = PROD_W'(1) << RAND_W;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  epoch_q, nodes_q;
  logic [CNT_W-1:0]  eff_e, eff_n;
  logic [IDX_W-1:0]  phase_q;
  logic [CNT_W-1:0]  heads_q, heads_d;
  logic [CNT_W-1:0]  lq_q, lq_d;
  logic [RAND_W-1:0] rv_q;
  logic              div_fin_q, div_fin_d;
  logic              accept;
  logic [CNT_W-1:0]  span;
  logic [PROD_W-1:0] prod;
  logic              draw_ok;

  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_num;
  logic [CNT_W-1:0]  div_den, div_rem;

  che_cmd_t  cmd;
  che_scan_t scan_w [NODES+1];
  che_qry_t  qa_w   [NODES+1];
  che_qry_t  qb_w   [NODES+1];
  che_scan_t scan_end;
  che_qry_t  q_end;

  // Configuration registers, clamped into range where used.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= EPOCH_RST;
      nodes_q <= NODES_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_EPOCH) begin
        epoch_q <= cfg_data_i;
      end else begin
        nodes_q <= cfg_data_i;
      end
    end
  end

  assign eff_e = (epoch_q == '0) ? CNT_W'(1) :
                 (epoch_q > CNT_W'(EPOCH_MAX)) ? CNT_W'(EPOCH_MAX) : epoch_q;
  assign eff_n = (nodes_q > CNT_W'(NODES)) ? CNT_W'(NODES) : nodes_q;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = state_q != ST_IDLE;

  // Draw threshold: elect when u * (epoch - phase) <= 2^RANDOM_BITS.
  assign span = (eff_e > {1'b0, phase_q}) ? eff_e - {1'b0, phase_q} : CNT_W'(1);
  assign prod = {{CNT_W{1'b0}}, in_i.random_value} * {{RAND_W{1'b0}}, span};
  assign draw_ok = {1'b0, in_i.node_index} < eff_n && prod <= DRAW_LIM;

  // Broadcast to the cells.
  always_comb begin
    cmd            = '0;
    cmd.load       = accept && in_i.action == ACT_LOAD;
    cmd.set_alive  = accept && in_i.action == ACT_ALIVE;
    cmd.draw       = accept && in_i.action == ACT_DRAW && draw_ok;
    cmd.clr_head   = div_done && !div_fin_q;
    cmd.clr_served = div_done && !div_fin_q && div_rem == '0;
    cmd.idx        = in_i.node_index;
    cmd.x          = in_i.x_position;
    cmd.y          = in_i.y_position;
    cmd.alive      = in_i.node_alive;
    cmd.nodes      = eff_n;
  end

  assign scan_end = scan_w[NODES];
  assign q_end    = qb_w[NODES];

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    heads_d   = heads_q;
    lq_d      = lq_q;
    div_fin_d = div_fin_q;
    div_start = 1'b0;
    div_num   = DIV_W'(rv_q);
    div_den   = scan_end.elig;
    scan_w[0] = '0;
    qa_w[0]   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_i.action == ACT_ROUND) begin
          div_start = 1'b1;
          div_num   = DIV_W'(in_i.round_number) + DIV_W'(eff_e) - DIV_W'(1);
          div_den   = eff_e;
          div_fin_d = 1'b0;
          state_d   = ST_DIV;
        end else if (accept && in_i.action == ACT_FINISH && eff_n != '0) begin
          scan_w[0].valid = 1'b1;
          scan_w[0].mode  = SCAN_COUNT;
          state_d         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end.valid) begin
          lq_d = '0;
          if (scan_end.mode == SCAN_PICK) begin
            heads_d = CNT_W'(1);
            state_d = ST_ASSIGN;
          end else begin
            heads_d = scan_end.heads;
            if (scan_end.heads == '0 && scan_end.elig != '0) begin
              div_start = 1'b1;
              div_fin_d = 1'b1;
              state_d   = ST_DIV;
            end else begin
              state_d = ST_ASSIGN;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_fin_q) begin
            // Place the fallback head at the remainder among eligible nodes.
            scan_w[0].valid = 1'b1;
            scan_w[0].mode  = SCAN_PICK;
            scan_w[0].pick  = div_rem;
            state_d         = ST_SCAN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ASSIGN: begin
        if (lq_q < eff_n) begin
          qa_w[0].valid = 1'b1;
          qa_w[0].node  = lq_q[IDX_W-1:0];
          lq_d          = lq_q + CNT_W'(1);
        end
        if (q_end.valid && res_o.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= '0;
      heads_q   <= '0;
      lq_q      <= '0;
      div_fin_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      heads_q   <= heads_d;
      lq_q      <= lq_d;
      div_fin_q <= div_fin_d;
      if (div_done && !div_fin_q) begin
        phase_q <= div_rem[IDX_W-1:0];
      end
    end
  end

  // Hold the finish word's random value for the fallback pick.
  always_ff @(posedge clk_i) begin
    if (accept && in_i.action == ACT_FINISH) begin
      rv_q <= in_i.random_value;
    end
  end

  che_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  // Capture row feeds straight into the distance row.
  assign qb_w[0] = qa_w[NODES];

  for (genvar g = 0; g < NODES; g++) begin : g_cell
    che_cell #(
      .IDX (IDX_W'(g))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .scan_i (scan_w[g]),
      .scan_o (scan_w[g+1]),
      .qa_i   (qa_w[g]),
      .qa_o   (qa_w[g+1]),
      .qb_i   (qb_w[g]),
      .qb_o   (qb_w[g+1])
    );
  end

  // Format the result word from the query leaving the row.
  always_comb begin
    res_o            = '0;
    res_o.out_node   = q_end.node;
    res_o.head_count = heads_q;
    res_o.last       = ({1'b0, q_end.node} + CNT_W'(1)) == eff_n;
    if (q_end.alive) begin
      if (q_end.head) begin
        res_o.head_index = q_end.node;
        res_o.has_head   = 1'b1;
        res_o.is_head    = 1'b1;
      end else begin
        res_o.head_index = q_end.hidx;
        res_o.has_head   = q_end.has;
      end
    end
  end

  assign res_valid_o = q_end.valid;

endmodule

>>> rtl/core/che_chk.sv
// Port-level checker for the cluster head election block, with its bind.
`include "cluster_head_election_top_assert.svh"

module che_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              busy_o,
  input logic              res_valid_o,
  input che_pkg::che_out_t res_o
);

  `CHE_ASSERT_NOW(a_res_while_busy, res_valid_o, busy_o)
  `CHE_ASSERT_NEXT(a_run_contiguous, res_valid_o && !res_o.last, res_valid_o)
  `CHE_ASSERT_NEXT(a_last_ends_run, res_valid_o && res_o.last, !res_valid_o)
  `CHE_ASSERT_NOW(a_head_self, res_valid_o && res_o.is_head,
                  res_o.has_head && res_o.head_index == res_o.out_node)

endmodule

bind cluster_head_election_top che_chk u_che_chk (.*);

>>> verif/testbench.sv
// Self-checking testbench for the cluster head election block.
`timescale 1ns / 1ps

module testbench;
  import che_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  che_in_t              in_i = '0;
  logic                 res_valid_o;
  che_out_t             res_o;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_idx_i = 1'b0;
  logic [CNT_W-1:0]     cfg_data_i = '0;

  cluster_head_election_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o), .in_i(in_i),
    .res_valid_o(res_valid_o), .res_o(res_o), .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Shadow of the node table and settings, kept by the predictor.
  logic [COORD_W-1:0] node_x [NODES];
  logic [COORD_W-1:0] node_y [NODES];
  logic [NODES-1:0]   alive_q, served_q, head_q;
  int unsigned        phase_q;
  logic [CNT_W-1:0]   epoch_len_q, nodes_q;
  logic [NODES-1:0]   placed;   // entries with a known position

  che_in_t  word_q [$];         // words waiting for the driver
  che_out_t assign_q [$];       // predicted assignment words
  int       errors = 0;
  bit       quiet = 0;          // drop driver gaps near the end
  int       gap = 0;

  function automatic int unsigned eff_epoch();
    if (epoch_len_q == 0) return 1;
    if (epoch_len_q > 64) return 64;
    return epoch_len_q;
  endfunction

  function automatic int unsigned eff_nodes();
    return (nodes_q > NODES) ? NODES : nodes_q;
  endfunction

  // Advance the shadow state for one accepted word and queue any results.
  task automatic predict_election(input che_in_t w);
    int unsigned n, e, heads, elig, pick, hidx;
    logic has, ish;
    longint unsigned best, d, dx, dy;
    che_out_t res_w;
    n = eff_nodes();
    case (w.action)
      ACT_LOAD: begin
        node_x[w.node_index] = w.x_position;
        node_y[w.node_index] = w.y_position;
        alive_q[w.node_index] = w.node_alive;
      end
      ACT_ALIVE: alive_q[w.node_index] = w.node_alive;
      ACT_ROUND: begin
        e = eff_epoch();
        phase_q = (w.round_number + e - 1) % e;
        head_q = '0;
        if (phase_q == 0) served_q = '0;
      end
      ACT_DRAW: begin
        if (w.node_index < n && alive_q[w.node_index] && !served_q[w.node_index]) begin
          e = eff_epoch();
          d = (e > phase_q) ? e - phase_q : 1;
          if (longint'(w.random_value) * d <= 65536) begin
            head_q[w.node_index] = 1'b1;
            served_q[w.node_index] = 1'b1;
          end
        end
      end
      ACT_FINISH: begin
        heads = 0;
        for (int i = 0; i < n; i++) if (alive_q[i] && head_q[i]) heads++;
        if (heads == 0) begin
          elig = 0;
          for (int i = 0; i < n; i++) if (alive_q[i] && !served_q[i]) elig++;
          if (elig != 0) begin
            pick = w.random_value % elig;
            for (int i = 0; i < n; i++) begin
              if (alive_q[i] && !served_q[i]) begin
                if (pick == 0) begin
                  head_q[i] = 1'b1;
                  served_q[i] = 1'b1;
                  heads = 1;
                  break;
                end
                pick--;
              end
            end
          end
        end
        for (int i = 0; i < n; i++) begin
          hidx = 0; has = 0; ish = 0; best = 0;
          if (alive_q[i]) begin
            if (head_q[i]) begin
              hidx = i; has = 1; ish = 1;
            end else begin
              for (int j = 0; j < n; j++) begin
                if (!alive_q[j] || !head_q[j]) continue;
                dx = (node_x[i] > node_x[j]) ? node_x[i] - node_x[j] : node_x[j] - node_x[i];
                dy = (node_y[i] > node_y[j]) ? node_y[i] - node_y[j] : node_y[j] - node_y[i];
                d = dx * dx + dy * dy;
                if (!has || d < best) begin
                  best = d; hidx = j; has = 1;
                end
              end
            end
          end
          res_w.out_node   = IDX_W'(i);
          res_w.head_index = IDX_W'(hidx);
          res_w.has_head   = has;
          res_w.is_head    = ish;
          res_w.head_count = CNT_W'(heads);
          res_w.last       = (i + 1 == n);
          assign_q = {assign_q, res_w};
        end
      end
      default: ;
    endcase
  endtask

  // Driver: hold start until the block takes the word, then advance.
  always @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      predict_election(in_i);
      void'(word_q.pop_front());
    end
    if (start_i && busy_o) begin
      // hold the word
    end else if (gap > 0) begin
      gap <= gap - 1;
      start_i <= 1'b0;
    end else if ((start_i && !busy_o ? word_q.size() : word_q.size()) > 0) begin
      if (!quiet && $urandom_range(0, 7) == 0) begin
        gap <= $urandom_range(1, 15);
        start_i <= 1'b0;
      end else begin
        in_i <= word_q[0];
        start_i <= 1'b1;
      end
    end else begin
      start_i <= 1'b0;
    end
  end

  // Monitor: compare every result word with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (assign_q.size() == 0) begin
        $error("unexpected result word node %0d", res_o.out_node);
        errors++;
      end else begin
        che_out_t exp_w;
        exp_w = assign_q.pop_front();
        if (res_o.out_node !== exp_w.out_node) begin
          $error("out_node exp %0d got %0d", exp_w.out_node, res_o.out_node); errors++;
        end
        if (res_o.head_index !== exp_w.head_index) begin
          $error("head_index exp %0d got %0d", exp_w.head_index, res_o.head_index); errors++;
        end
        if (res_o.has_head !== exp_w.has_head) begin
          $error("has_head exp %0d got %0d", exp_w.has_head, res_o.has_head); errors++;
        end
        if (res_o.is_head !== exp_w.is_head) begin
          $error("is_head exp %0d got %0d", exp_w.is_head, res_o.is_head); errors++;
        end
        if (res_o.head_count !== exp_w.head_count) begin
          $error("head_count exp %0d got %0d", exp_w.head_count, res_o.head_count); errors++;
        end
        if (res_o.last !== exp_w.last) begin
          $error("last exp %0d got %0d", exp_w.last, res_o.last); errors++;
        end
      end
    end
  end

  function automatic che_in_t mk(input int act, input int idx, input int x,
                                 input int y, input int al, input int rnd, input int rv);
    che_in_t w;
    w.action = 3'(act); w.node_index = IDX_W'(idx); w.x_position = COORD_W'(x);
    w.y_position = COORD_W'(y); w.node_alive = 1'(al); w.round_number = ROUND_W'(rnd);
    w.random_value = RAND_W'(rv);
    return w;
  endfunction

  // Queue a word, marking the node of a load word as placed.
  task automatic push_word(input che_in_t w);
    if (w.action == ACT_LOAD) placed[w.node_index] = 1'b1;
    word_q = {word_q, w};
  endtask

  // Wait for the block to drain before touching configuration.
  task automatic settle();
    while (word_q.size() != 0 || start_i) @(posedge clk_i);
    while (assign_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= CNT_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_EPOCH) epoch_len_q = CNT_W'(val); else nodes_q = CNT_W'(val);
  endtask

  // Load every node in use with a random position.
  task automatic fill_table(input int n);
    for (int i = 0; i < n; i++)
      push_word(mk(ACT_LOAD, i, $urandom, $urandom, $urandom_range(0, 5) != 0, 0, 0));
  endtask

  // One round: begin, draws mixed with alive updates and bad actions, finish.
  task automatic play_round(input int n, input int rnd);
    push_word(mk(ACT_ROUND, $urandom, $urandom, $urandom, $urandom, rnd, $urandom));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0)
        push_word(mk(ACT_ALIVE, $urandom_range(0, n - 1), 0, 0, $urandom, 0, 0));
      else if ($urandom_range(0, 19) == 0)
        push_word(mk($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom));
      else
        push_word(mk(ACT_DRAW, $urandom_range(0, 63), $urandom, $urandom, $urandom,
                     $urandom, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 9000)));
    end
    push_word(mk(ACT_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
  endtask

  initial begin
    int n, rnd;
    alive_q = '0; served_q = '0; head_q = '0; phase_q = 0; placed = '0;
    epoch_len_q = EPOCH_RST; nodes_q = NODES_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes of coordinates and indices, every action, fallback pick.
    push_word(mk(ACT_LOAD, 0, 0, 0, 1, 0, 0));
    push_word(mk(ACT_LOAD, 63, 16'hFFFF, 16'hFFFF, 1, 0, 0));
    for (int i = 1; i < 63; i++) push_word(mk(ACT_LOAD, i, $urandom, $urandom, 1, 0, 0));
    push_word(mk(ACT_ALIVE, 5, 0, 0, 0, 0, 0));
    push_word(mk(7, 1, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF));
    push_word(mk(ACT_ROUND, 0, 0, 0, 0, 0, 0));          // round zero wraps
    push_word(mk(ACT_FINISH, 0, 0, 0, 0, 0, 16'hFFFF));  // fallback head
    push_word(mk(ACT_ROUND, 0, 0, 0, 0, 1, 0));
    push_word(mk(ACT_DRAW, 63, 0, 0, 0, 0, 0));
    push_word(mk(ACT_DRAW, 0, 0, 0, 0, 0, 16'hFFFF));
    push_word(mk(ACT_DRAW, 10, 0, 0, 0, 0, 3276));
    push_word(mk(ACT_FINISH, 0, 0, 0, 0, 0, 0));
    push_word(mk(ACT_ROUND, 0, 0, 0, 0, 16'hFFFF, 0));
    push_word(mk(ACT_FINISH, 0, 0, 0, 0, 0, 1));
    settle();

    // Several settings, extremes included; zero node count finishes with no words.
    write_reg(CFG_NODES, 0);
    write_reg(CFG_EPOCH, 0);
    push_word(mk(ACT_ROUND, 0, 0, 0, 0, 3, 0));
    push_word(mk(ACT_DRAW, 0, 0, 0, 0, 0, 0));
    push_word(mk(ACT_FINISH, 0, 0, 0, 0, 0, 0));
    settle();
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: begin write_reg(CFG_EPOCH, 1);   write_reg(CFG_NODES, 1);   end
        1: begin write_reg(CFG_EPOCH, 64);  write_reg(CFG_NODES, 8);   end
        2: begin write_reg(CFG_EPOCH, 127); write_reg(CFG_NODES, 127); end
        3: begin write_reg(CFG_EPOCH, 5);   write_reg(CFG_NODES, 16);  end
        4: begin write_reg(CFG_EPOCH, $urandom_range(2, 20)); write_reg(CFG_NODES, 12); end
        default: begin write_reg(CFG_EPOCH, 20); write_reg(CFG_NODES, 64); end
      endcase
      n = eff_nodes();
      // A full table keeps the positions loaded by the directed part.
      if (n > 0 && n < NODES) fill_table(n);
      rnd = $urandom_range(0, 3);
      for (int r = 0; r < ((n > 16) ? 1 : 2); r++) begin
        if (s == 5) quiet = 1;
        play_round(n, rnd + r + 1);
      end
      settle();
    end

    if (errors == 0) begin
      $display("PASS cluster_head_election_top");
    end else begin
      $display("FAIL cluster_head_election_top");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #20ms;
    $display("FAIL cluster_head_election_top");
    $finish;
  end

endmodule
